FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expands to one labeled concurrent assertion on clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/aphlm_pkg.sv
package aphlm_pkg;

  // Level format: unsigned Q0.16
  localparam int LEVEL_W = 16;
  // Width of the software registers
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // Item kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_REDRAW = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PER_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_MS  = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] SMOOTH_FACTOR_RST = 16'd58982;
  localparam logic [CFG_W-1:0] DECAY_PER_MS_RST  = 16'd66;
  localparam logic [CFG_W-1:0] HOLD_TIME_MS_RST  = 16'd2000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [LEVEL_W-1:0] rms_in;
    logic [LEVEL_W-1:0] peak_in;
  } aphlm_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_out;
    logic [LEVEL_W-1:0] decayed_peak_out;
    logic [LEVEL_W-1:0] hold_out;
  } aphlm_out_t;

endpackage

FILE: hw/rtl/audio_peak_hold_level_meter_top.sv
// Peak-hold level meter: one result beat for every input beat.
// Results go to the output register, or to the skid entry when output stalls.
// Throughput: one beat per cycle when not stalled. The state update completes
// in the accept cycle, with one multiplier for smoothing and one for peak decay.
// A two-entry output buffer accepts one more input beat under output stall.
// Reset (rst_n, synchronous): levels and ages to zero, registers to defaults.
`include "assert_macros.svh"

module audio_peak_hold_level_meter_top
  import aphlm_pkg::*;
#(
  parameter int AGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aphlm_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aphlm_out_t           out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int PROD_W  = LEVEL_W + CFG_W + 2;
  localparam int ACC_W   = PROD_W + 1;
  localparam int DECAY_W = CFG_W + AGE_BITS;
  localparam int CMP_W   = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (CFG_W - 1);

  // Software registers
  logic [CFG_W-1:0] smooth_r;
  logic [CFG_W-1:0] decay_r;
  logic [CFG_W-1:0] hold_time_r;

  // Meter state
  logic [LEVEL_W-1:0]  rms_r, rms_nxt;
  logic [LEVEL_W-1:0]  peak_r, peak_nxt;
  logic [LEVEL_W-1:0]  dpeak_r, dpeak_nxt;
  logic [LEVEL_W-1:0]  hold_r, hold_nxt;
  logic [AGE_BITS-1:0] peak_age_r, peak_age_nxt;
  logic [AGE_BITS-1:0] hold_age_r, hold_age_nxt;

  // Output buffer
  logic       out_valid_r;
  aphlm_out_t out_data_r;
  logic       skid_valid_r;
  aphlm_out_t skid_data_r;

  logic                      in_accept;
  logic                      out_free;
  logic signed [LEVEL_W:0]   rms_diff;
  logic signed [PROD_W-1:0]  smooth_prod;
  logic signed [ACC_W-1:0]   smooth_acc;
  logic [LEVEL_W-1:0]        rms_smooth;
  logic [DECAY_W-1:0]        decay_prod;
  logic                      decay_below;
  logic                      hold_expired;
  aphlm_out_t                result;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r    <= SMOOTH_FACTOR_RST;
      decay_r     <= DECAY_PER_MS_RST;
      hold_time_r <= HOLD_TIME_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMOOTH_FACTOR: smooth_r    <= cfg_wdata;
        REG_DECAY_PER_MS:  decay_r     <= cfg_wdata;
        REG_HOLD_TIME_MS:  hold_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Smooth RMS as rin + s*(rms - rin), rounded half up
  always_comb begin
    rms_diff    = $signed({1'b0, rms_r}) - $signed({1'b0, in_data.rms_in});
    smooth_prod = $signed({1'b0, smooth_r}) * rms_diff;
    smooth_acc  = $signed({{(ACC_W - LEVEL_W - CFG_W){1'b0}}, in_data.rms_in, {CFG_W{1'b0}}})
                + $signed({smooth_prod[PROD_W-1], smooth_prod}) + ROUND_HALF;
    rms_smooth  = smooth_acc[CFG_W +: LEVEL_W];
  end

  // Linear peak decay and hold timeout
  always_comb begin
    decay_prod   = decay_r * peak_age_r;
    decay_below  = decay_prod < DECAY_W'(peak_r);
    hold_expired = CMP_W'(hold_age_r) > CMP_W'(hold_time_r);
  end

  // Next state per kind
  always_comb begin
    rms_nxt      = rms_r;
    peak_nxt     = peak_r;
    dpeak_nxt    = dpeak_r;
    hold_nxt     = hold_r;
    peak_age_nxt = peak_age_r;
    hold_age_nxt = hold_age_r;
    unique case (in_data.kind)
      KIND_REPORT: begin
        rms_nxt = rms_smooth;
        if (in_data.peak_in > dpeak_r) begin
          peak_nxt     = in_data.peak_in;
          dpeak_nxt    = in_data.peak_in;
          peak_age_nxt = '0;
        end
        if (in_data.peak_in > hold_r) begin
          hold_nxt     = in_data.peak_in;
          hold_age_nxt = '0;
        end
      end
      KIND_TICK: begin
        peak_age_nxt = (peak_age_r == AGE_MAX) ? AGE_MAX : peak_age_r + 1'b1;
        hold_age_nxt = (hold_age_r == AGE_MAX) ? AGE_MAX : hold_age_r + 1'b1;
      end
      KIND_REDRAW: begin
        dpeak_nxt = decay_below ? peak_r - decay_prod[LEVEL_W-1:0] : '0;
        if (hold_expired) begin
          hold_nxt = '0;
        end
      end
      KIND_CLEAR: begin
        rms_nxt  = '0;
        peak_nxt = '0;
      end
      default: ;
    endcase
    result.rms_out          = rms_nxt;
    result.decayed_peak_out = dpeak_nxt;
    result.hold_out         = hold_nxt;
  end

  // Commit state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_r      <= '0;
      peak_r     <= '0;
      dpeak_r    <= '0;
      hold_r     <= '0;
      peak_age_r <= '0;
      hold_age_r <= '0;
    end else if (in_accept) begin
      rms_r      <= rms_nxt;
      peak_r     <= peak_nxt;
      dpeak_r    <= dpeak_nxt;
      hold_r     <= hold_nxt;
      peak_age_r <= peak_age_nxt;
      hold_age_r <= hold_age_nxt;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (!out_free && in_accept) begin
      skid_data_r <= result;
    end
  end

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid entry filled while output empty")
  `ASSERT_NEXT(a_clear_zeroes_rms, in_accept && out_free && in_data.kind == KIND_CLEAR, out_valid_r && out_data_r.rms_out == '0, "clear beat did not zero RMS")
  `ASSERT_NEXT(a_age_no_wrap, in_accept && in_data.kind == KIND_TICK && peak_age_r != '0, peak_age_r != '0, "peak age wrapped")
  `ASSERT_NEXT(a_decay_below_peak, in_accept && in_data.kind == KIND_REDRAW, dpeak_r <= peak_r, "decayed peak above peak after redraw")

endmodule

FILE: sim/tb_audio_peak_hold_level_meter_top.sv
module tb_audio_peak_hold_level_meter_top;
  import aphlm_pkg::*;

  // Register index that maps to nothing; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int MAX_REPORTS     = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int PHASE_BEATS     = 600;
  localparam int AGE_TICKS       = 80;

  typedef struct {
    aphlm_in_t  beat;
    bit         typed;
    aphlm_out_t levels;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  aphlm_in_t            in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  aphlm_out_t           out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Meter state and register copies used for prediction
  logic [LEVEL_W-1:0] lvl_rms, lvl_peak, lvl_decayed, lvl_hold;
  logic [15:0]        peak_age, hold_age;
  logic [CFG_W-1:0]   cfg_smooth, cfg_decay, cfg_hold_time;

  aphlm_out_t  pending_levels[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          pressure_req = 1'b0;
  int unsigned quiet_cycles = 0;

  audio_peak_hold_level_meter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Restore power-on levels, ages and register defaults
  task automatic meter_reset();
    lvl_rms       = '0;
    lvl_peak      = '0;
    lvl_decayed   = '0;
    lvl_hold      = '0;
    peak_age      = '0;
    hold_age      = '0;
    cfg_smooth    = SMOOTH_FACTOR_RST;
    cfg_decay     = DECAY_PER_MS_RST;
    cfg_hold_time = HOLD_TIME_MS_RST;
  endtask

  // Apply one beat to the meter state and return the displayed levels
  function automatic aphlm_out_t meter_update(input aphlm_in_t b);
    logic [63:0] acc;
    logic [31:0] decay;
    aphlm_out_t  r;
    case (b.kind)
      KIND_REPORT: begin
        acc = 64'(lvl_rms) * 64'(cfg_smooth)
            + 64'(b.rms_in) * (64'd65536 - 64'(cfg_smooth)) + 64'd32768;
        lvl_rms = acc[16 +: LEVEL_W];
        if (b.peak_in > lvl_decayed) begin
          lvl_peak    = b.peak_in;
          lvl_decayed = b.peak_in;
          peak_age    = '0;
        end
        if (b.peak_in > lvl_hold) begin
          lvl_hold = b.peak_in;
          hold_age = '0;
        end
      end
      KIND_TICK: begin
        if (peak_age != 16'hFFFF) peak_age = peak_age + 16'd1;
        if (hold_age != 16'hFFFF) hold_age = hold_age + 16'd1;
      end
      KIND_REDRAW: begin
        decay = 32'(cfg_decay) * 32'(peak_age);
        lvl_decayed = (decay < 32'(lvl_peak)) ? lvl_peak - decay[LEVEL_W-1:0] : '0;
        if (hold_age > cfg_hold_time) lvl_hold = '0;
      end
      default: begin
        lvl_rms  = '0;
        lvl_peak = '0;
      end
    endcase
    r.rms_out          = lvl_rms;
    r.decayed_peak_out = lvl_decayed;
    r.hold_out         = lvl_hold;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input logic [1:0] kind, input logic [15:0] rms,
                                       input logic [15:0] peak, input bit typed,
                                       input logic [15:0] e_rms, input logic [15:0] e_dec,
                                       input logic [15:0] e_hold);
    dir_row_t r;
    r.beat.kind               = kind;
    r.beat.rms_in             = rms;
    r.beat.peak_in            = peak;
    r.typed                   = typed;
    r.levels.rms_out          = e_rms;
    r.levels.decayed_peak_out = e_dec;
    r.levels.hold_out         = e_hold;
    return r;
  endfunction

  // Mostly reports, ticks and redraws; quiet peaks now and then
  function automatic aphlm_in_t random_meter_beat();
    aphlm_in_t   b;
    int unsigned pick;
    b.rms_in  = 16'($urandom);
    b.peak_in = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35)      b.kind = KIND_REPORT;
    else if (pick < 65) b.kind = KIND_TICK;
    else if (pick < 93) b.kind = KIND_REDRAW;
    else                b.kind = KIND_CLEAR;
    if ($urandom_range(0, 3) == 0) b.peak_in = 16'($urandom_range(0, 4095));
    return b;
  endfunction

  // Offer one beat, hold it until accepted, then queue its expected levels
  task automatic offer_beat(input aphlm_in_t b, input bit typed, input aphlm_out_t typed_levels);
    aphlm_out_t predicted;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    predicted = meter_update(b);
    pending_levels.push_back(typed ? typed_levels : predicted);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain_meter();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_levels.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SMOOTH_FACTOR: cfg_smooth    = val;
      REG_DECAY_PER_MS:  cfg_decay     = val;
      REG_HOLD_TIME_MS:  cfg_hold_time = val;
      default: ;
    endcase
  endtask

  // Write all registers plus a stray write to the unused index
  task automatic program_regs(input logic [CFG_W-1:0] smooth, input logic [CFG_W-1:0] decay,
                              input logic [CFG_W-1:0] hold_ms);
    write_reg(REG_SMOOTH_FACTOR, smooth);
    write_reg(REG_SPARE, CFG_W'($urandom));
    write_reg(REG_DECAY_PER_MS, decay);
    write_reg(REG_HOLD_TIME_MS, hold_ms);
    cfg_valid <= 1'b0;
  endtask

  // Random beats with occasional tick bursts so ages build up
  task automatic run_random_phase(input int beats, input int pressure_at);
    aphlm_in_t b;
    int        n;
    int        burst;
    n = 0;
    while (n < beats) begin
      if (pressure_at >= 0 && n >= pressure_at) pressure_req = 1'b1;
      if ($urandom_range(0, 99) < 8) begin
        burst = $urandom_range(3, 40);
        repeat (burst) begin
          b = random_meter_beat();
          b.kind = KIND_TICK;
          offer_beat(b, 1'b0, '0);
        end
        n += burst;
      end else begin
        offer_beat(random_meter_beat(), 1'b0, '0);
        n++;
      end
    end
  endtask

  // Compare one result beat with the oldest expected levels
  task automatic check_levels(input aphlm_out_t got);
    aphlm_out_t want;
    if (pending_levels.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result: rms %h decayed peak %h hold %h",
                 got.rms_out, got.decayed_peak_out, got.hold_out);
      return;
    end
    want = pending_levels.pop_front();
    if (got.rms_out !== want.rms_out || got.decayed_peak_out !== want.decayed_peak_out ||
        got.hold_out !== want.hold_out) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("level error: rms exp %h got %h, decayed peak exp %h got %h, hold exp %h got %h",
                 want.rms_out, got.rms_out, want.decayed_peak_out, got.decayed_peak_out,
                 want.hold_out, got.hold_out);
    end
  endtask

  // Check every result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_levels(out_data);
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("audio_peak_hold_level_meter_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit          held;
    int unsigned n;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
      end
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin : stimulus
    dir_row_t  rows[$];
    aphlm_in_t b;
    int        i;

    meter_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero smoothing weight, full decay rate, zero hold time
    program_regs(16'd0, 16'hFFFF, 16'd0);
    rows.push_back(dir_row(KIND_TICK,   16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, 16'h0000));
    rows.push_back(dir_row(KIND_REDRAW, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, 16'h0000));
    rows.push_back(dir_row(KIND_REPORT, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    rows.push_back(dir_row(KIND_REDRAW, 16'h0000, 16'h0000, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    rows.push_back(dir_row(KIND_TICK,   16'h0000, 16'h0000, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    rows.push_back(dir_row(KIND_REDRAW, 16'h0000, 16'h0000, 1, 16'hFFFF, 16'h0000, 16'h0000));
    rows.push_back(dir_row(KIND_REPORT, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, 16'h0000));
    rows.push_back(dir_row(KIND_REPORT, 16'h0001, 16'h0001, 1, 16'h0001, 16'h0001, 16'h0001));
    rows.push_back(dir_row(KIND_REPORT, 16'h8000, 16'h8000, 1, 16'h8000, 16'h8000, 16'h8000));
    rows.push_back(dir_row(KIND_CLEAR,  16'hFFFF, 16'hFFFF, 1, 16'h0000, 16'h8000, 16'h8000));
    rows.push_back(dir_row(KIND_REDRAW, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, 16'h8000));
    rows.push_back(dir_row(KIND_REPORT, 16'h5555, 16'hAAAA, 1, 16'h5555, 16'hAAAA, 16'hAAAA));
    rows.push_back(dir_row(KIND_REPORT, 16'hAAAA, 16'h5555, 1, 16'hAAAA, 16'hAAAA, 16'hAAAA));
    rows.push_back(dir_row(KIND_TICK,   16'h1234, 16'hFFFF, 0, '0, '0, '0));
    rows.push_back(dir_row(KIND_REDRAW, 16'h0000, 16'h0000, 0, '0, '0, '0));
    rows.push_back(dir_row(KIND_REPORT, 16'h7FFF, 16'h0001, 0, '0, '0, '0));
    rows.push_back(dir_row(KIND_TICK,   16'hFFFF, 16'h0000, 0, '0, '0, '0));
    rows.push_back(dir_row(KIND_REPORT, 16'h0000, 16'hFFFE, 0, '0, '0, '0));
    rows.push_back(dir_row(KIND_CLEAR,  16'h1234, 16'h5678, 0, '0, '0, '0));
    rows.push_back(dir_row(KIND_REDRAW, 16'hFFFF, 16'hFFFF, 0, '0, '0, '0));
    for (i = 0; i < rows.size(); i++) offer_beat(rows[i].beat, rows[i].typed, rows[i].levels);
    drain_meter();

    // Sender idles lightly, receiver heavily; default smoothing, short hold
    send_idle_pct = 24;
    recv_idle_pct = 68;
    program_regs(SMOOTH_FACTOR_RST, 16'($urandom_range(200, 3000)),
                 16'($urandom_range(0, 30)));
    run_random_phase(PHASE_BEATS, -1);
    drain_meter();

    // Roles swapped; full smoothing weight and no decay
    send_idle_pct = 68;
    recv_idle_pct = 24;
    program_regs(16'hFFFF, 16'd0, 16'($urandom_range(5, 60)));
    run_random_phase(PHASE_BEATS, -1);
    drain_meter();

    // No idling; random registers; long receiver hold-off partway through
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 100)));
    run_random_phase(PHASE_BEATS, 200);
    drain_meter();

    // Long tick run: a maximum hold time never clears the hold level
    program_regs(16'($urandom), 16'd1, 16'hFFFF);
    b = random_meter_beat();
    b.kind    = KIND_REPORT;
    b.peak_in = 16'hFFFF;
    offer_beat(b, 1'b0, '0);
    repeat (AGE_TICKS) begin
      b = random_meter_beat();
      b.kind = KIND_TICK;
      offer_beat(b, 1'b0, '0);
    end
    b.kind = KIND_REDRAW;
    offer_beat(b, 1'b0, '0);
    drain_meter();
    // Zero hold time: now the hold level drops
    program_regs(16'($urandom), 16'd1, 16'd0);
    offer_beat(b, 1'b0, '0);
    drain_meter();

    repeat (4) @(posedge clk);
    if (pending_levels.size() != 0) begin
      mismatches += pending_levels.size();
      $display("%0d expected results never arrived", pending_levels.size());
    end
    if (mismatches == 0) begin
      $display("audio_peak_hold_level_meter_top: match");
    end else begin
      $display("audio_peak_hold_level_meter_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/aphlm_pkg.sv
hw/rtl/audio_peak_hold_level_meter_top.sv
sim/tb_audio_peak_hold_level_meter_top.sv
